[src/djd_pkg.sv]
// Package for the diagonal joypad debounce decoder: widths, register indexes, key type.
`timescale 1ns / 1ps

package djd_pkg;

	localparam int PinCount       = 8;
	localparam int DirCount       = 5;
	localparam int MaskWidth      = PinCount * DirCount;
	localparam int CountWidth     = 4;
	localparam int TickWidth      = 16;
	localparam int CfgIndexWidth  = 3;
	localparam int CfgDataWidth   = 40;
	localparam int DefaultMaxButtons = 8;
	localparam logic [TickWidth-1:0] DebounceReset = TickWidth'(50);

	// Direction order inside one button's five-bit mask.
	localparam int DirUp    = 0;
	localparam int DirRight = 1;
	localparam int DirLeft  = 2;
	localparam int DirDown  = 3;
	localparam int DirEnter = 4;

	typedef enum logic [CfgIndexWidth-1:0] {
		CFG_BUTTON_COUNT  = 3'd0,
		CFG_ACTIVE_LOW    = 3'd1,
		CFG_DIR_MASKS     = 3'd2,
		CFG_ENTER_BLOCKED = 3'd3,
		CFG_DEBOUNCE      = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic up;
		logic right;
		logic left;
		logic down;
		logic enter;
	} key_set_t;

	// Pins below the saturated button count are enabled.
	function automatic logic [PinCount-1:0] enabled_pins(
		input logic [CountWidth-1:0] count,
		input logic [CountWidth-1:0] max_count
	);
		logic [CountWidth-1:0] n;
		logic [PinCount-1:0]   m;
		n = (count > max_count) ? max_count : count;
		for (int i = 0; i < PinCount; i++) begin
			m[i] = (CountWidth'(i) < n);
		end
		return m;
	endfunction

endpackage

[src/djd_vote.sv]
// Vote counting and key decision for one evaluated set of pin levels.
`timescale 1ns / 1ps

module djd_vote (
	input  logic [djd_pkg::PinCount-1:0]  levels,
	input  logic [djd_pkg::PinCount-1:0]  enabled,
	input  logic [djd_pkg::PinCount-1:0]  active_low_mask,
	input  logic [djd_pkg::MaskWidth-1:0] direction_masks,
	input  logic                          enter_blocked_by_direction,
	output djd_pkg::key_set_t             keys
);

	localparam int VoteWidth = $clog2(djd_pkg::PinCount + 1);

	logic [djd_pkg::PinCount-1:0] pressed;
	logic [djd_pkg::PinCount-1:0] column [djd_pkg::DirCount];
	logic [VoteWidth-1:0]         votes  [djd_pkg::DirCount];
	logic [VoteWidth-1:0]         top_ab, top_cd, top;

	assign pressed = (levels ^ active_low_mask) & enabled;

	// Gather, for each direction, the pressed buttons that vote for it.
	always_comb begin
		for (int j = 0; j < djd_pkg::DirCount; j++) begin
			for (int i = 0; i < djd_pkg::PinCount; i++) begin
				column[j][i] = pressed[i] & direction_masks[djd_pkg::DirCount*i + j];
			end
			votes[j] = VoteWidth'($countones(column[j]));
		end
	end

	assign top_ab = (votes[djd_pkg::DirUp] > votes[djd_pkg::DirRight]) ?
		votes[djd_pkg::DirUp] : votes[djd_pkg::DirRight];
	assign top_cd = (votes[djd_pkg::DirLeft] > votes[djd_pkg::DirDown]) ?
		votes[djd_pkg::DirLeft] : votes[djd_pkg::DirDown];
	assign top = (top_ab > top_cd) ? top_ab : top_cd;

	always_comb begin
		keys.up    = (top != '0) && (votes[djd_pkg::DirUp] == top);
		keys.right = (top != '0) && (votes[djd_pkg::DirRight] == top);
		keys.left  = (top != '0) && (votes[djd_pkg::DirLeft] == top);
		keys.down  = (top != '0) && (votes[djd_pkg::DirDown] == top);
		keys.enter = (votes[djd_pkg::DirEnter] != '0) &&
			(!enter_blocked_by_direction || (top == '0));
	end

endmodule

[src/diagonal_joypad_debounce_decoder_top.sv]
// Top level of the diagonal joypad debounce decoder.
`timescale 1ns / 1ps

// Each input word is one time tick carrying the sampled levels of up to eight
// button pins, and the block takes one word every clock cycle while in_stall
// is low. A level change on any enabled pin (re)loads a settle countdown with
// debounce_ticks (zero counts as one); every later tick without an edge
// counts it down, and the tick on which it runs out evaluates that tick's
// levels and yields exactly one result word. Ticks that do not evaluate yield
// nothing. An edge on the same tick as an expiry wins and restarts the
// countdown. Previous levels reset to zero, so a pin that is high on the
// first tick counts as an edge. The edge and countdown logic runs at the
// input and registers the levels in the stage register; the vote counting
// runs from the stage register into the output register. in_stall is raised
// only when both the stage register and the output register are full and
// out_stall is high. Configuration registers must be written only while no
// result is in flight.

module diagonal_joypad_debounce_decoder_top #(
	parameter int MAX_BUTTONS = djd_pkg::DefaultMaxButtons
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [djd_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  logic [djd_pkg::CfgDataWidth-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [djd_pkg::PinCount-1:0]        pin_levels,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                pad_up,
	output logic                                pad_right,
	output logic                                pad_left,
	output logic                                pad_down,
	output logic                                pad_enter
);

	localparam logic [djd_pkg::CountWidth-1:0] MaxCount = djd_pkg::CountWidth'(MAX_BUTTONS);

	// Configuration registers.
	logic [djd_pkg::CountWidth-1:0] button_count_q;
	logic [djd_pkg::PinCount-1:0]   active_low_q;
	logic [djd_pkg::MaskWidth-1:0]  dir_masks_q;
	logic                           enter_blocked_q;
	logic [djd_pkg::TickWidth-1:0]  debounce_q;

	// Debounce state.
	logic [djd_pkg::PinCount-1:0]   prev_levels_q;
	logic [djd_pkg::TickWidth-1:0]  countdown_q;
	logic                           pending_q;

	// Stage register and output register.
	logic                           valid_s1;
	logic [djd_pkg::PinCount-1:0]   levels_s1;
	logic                           out_valid_q;
	djd_pkg::key_set_t              keys_q;

	logic [djd_pkg::PinCount-1:0]   enabled;
	logic                           accept;
	logic                           has_edge;
	logic                           evaluate;
	logic                           advance;
	logic [djd_pkg::TickWidth-1:0]  reload;
	djd_pkg::key_set_t              keys_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_count_q  <= '0;
			active_low_q    <= '0;
			dir_masks_q     <= '0;
			enter_blocked_q <= 1'b0;
			debounce_q      <= djd_pkg::DebounceReset;
		end else if (cfg_write) begin
			unique case (djd_pkg::cfg_idx_t'(cfg_index))
				djd_pkg::CFG_BUTTON_COUNT: begin
					button_count_q <= cfg_data[djd_pkg::CountWidth-1:0];
				end
				djd_pkg::CFG_ACTIVE_LOW: begin
					active_low_q <= cfg_data[djd_pkg::PinCount-1:0];
				end
				djd_pkg::CFG_DIR_MASKS: begin
					dir_masks_q <= cfg_data[djd_pkg::MaskWidth-1:0];
				end
				djd_pkg::CFG_ENTER_BLOCKED: begin
					enter_blocked_q <= cfg_data[0];
				end
				djd_pkg::CFG_DEBOUNCE: begin
					debounce_q <= cfg_data[djd_pkg::TickWidth-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign enabled  = djd_pkg::enabled_pins(button_count_q, MaxCount);
	assign has_edge = ((pin_levels ^ prev_levels_q) & enabled) != '0;
	assign reload   = (debounce_q == '0) ? djd_pkg::TickWidth'(1) : debounce_q;

	// A tick evaluates when no edge occurs and a running countdown reaches its end.
	assign evaluate = !has_edge && pending_q && (countdown_q <= djd_pkg::TickWidth'(1));

	// The output register takes a new word when it is empty or being read.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_levels_q <= '0;
			countdown_q   <= '0;
			pending_q     <= 1'b0;
		end else if (accept) begin
			prev_levels_q <= pin_levels;
			if (has_edge) begin
				countdown_q <= reload;
				pending_q   <= 1'b1;
			end else if (pending_q) begin
				if (countdown_q > djd_pkg::TickWidth'(1)) begin
					countdown_q <= countdown_q - djd_pkg::TickWidth'(1);
				end else begin
					countdown_q <= '0;
					pending_q   <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && evaluate) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && evaluate) begin
			levels_s1 <= pin_levels;
		end
	end

	djd_vote u_vote (
		.levels                     (levels_s1),
		.enabled                    (enabled),
		.active_low_mask            (active_low_q),
		.direction_masks            (dir_masks_q),
		.enter_blocked_by_direction (enter_blocked_q),
		.keys                       (keys_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			keys_q <= keys_d;
		end
	end

	assign out_valid = out_valid_q;
	assign pad_up    = keys_q.up;
	assign pad_right = keys_q.right;
	assign pad_left  = keys_q.left;
	assign pad_down  = keys_q.down;
	assign pad_enter = keys_q.enter;

endmodule

[src/djd_checker.sv]
// Port-level checker for the diagonal joypad debounce decoder, bound to the top level.
`timescale 1ns / 1ps

module djd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic pad_up,
	input logic pad_right,
	input logic pad_left,
	input logic pad_down,
	input logic pad_enter
);

	// A stalled result word stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// A stalled result word keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({pad_up, pad_right, pad_left, pad_down, pad_enter}))
		else $error("result word changed while stalled");

	// The input only backs up when the result side is full and stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while the output could drain");

	// A new result traces back to an accepted tick that passed through the stage register into the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result word without a matching accepted tick");

endmodule

bind diagonal_joypad_debounce_decoder_top djd_checker u_djd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pad_up    (pad_up),
	.pad_right (pad_right),
	.pad_left  (pad_left),
	.pad_down  (pad_down),
	.pad_enter (pad_enter)
);
